// ===== design/fwf_pkg.sv =====
// fwf_pkg: shared types and constants of the FIR filter with warm-up.
// Depends on nothing; used by the interfaces, the tap cell and the top level.
`default_nettype none

package fwf_pkg;

    localparam int SAMPLE_W  = 16;   // Q1.15 sample and coefficient
    localparam int PROD_W    = 32;   // Q2.30 product
    localparam int ACC_W     = 36;   // Q6.30 sum, room for eight products
    localparam int NUM_COEFS = 8;    // coefficient registers on the config port
    localparam int CFG_IDX_W = 3;    // register index width

    typedef enum logic {
        KIND_FILTER = 1'b0,
        KIND_PRIME  = 1'b1
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } t_state;

    // Per-cell control strobes.
    typedef struct packed {
        logic shift;     // take the sample from the newer neighbor
        logic prime;     // load the priming value
        logic coef_we;   // load the coefficient
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/fwf_in_if.sv =====
// fwf_in_if: input channel of the FIR filter (valid/ready plus kind and sample).
// Depends on fwf_pkg.
`default_nettype none

interface fwf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic signed [fwf_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/fwf_out_if.sv =====
// fwf_out_if: result channel of the FIR filter (valid/ready plus filtered).
// Depends on fwf_pkg.
`default_nettype none

interface fwf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fwf_pkg::ACC_W-1:0]    filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ===== design/fwf_tap_cell.sv =====
// fwf_tap_cell: one tap of the filter: window sample, coefficient, product
// and a partial-sum stage that feeds the next cell. Depends on fwf_pkg.
`default_nettype none

module fwf_tap_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fwf_pkg::t_cell_ctl                  i_ctl,
    input  wire logic signed [fwf_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic signed [fwf_pkg::SAMPLE_W-1:0] i_prime_val,
    input  wire logic signed [fwf_pkg::SAMPLE_W-1:0] i_coef,
    input  wire logic signed [fwf_pkg::ACC_W-1:0]    i_psum,
    output logic signed [fwf_pkg::SAMPLE_W-1:0]      o_sample,
    output logic signed [fwf_pkg::ACC_W-1:0]         o_psum
);

    logic signed [fwf_pkg::SAMPLE_W-1:0] r_coef;
    logic signed [fwf_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [fwf_pkg::PROD_W-1:0]   r_prod;
    logic signed [fwf_pkg::ACC_W-1:0]    r_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_ctl.coef_we) begin
            r_coef <= i_coef;
        end
    end

    // Window entry: prime overrides the shift.
    always_ff @(posedge i_clk) begin
        if (i_ctl.prime) begin
            r_sample <= i_prime_val;
        end else if (i_ctl.shift) begin
            r_sample <= i_sample;
        end
    end

    // Product and partial sum run freely; they settle while the window holds.
    always_ff @(posedge i_clk) begin
        r_prod <= r_sample * r_coef;
        r_psum <= i_psum + fwf_pkg::ACC_W'(r_prod);
    end

    assign o_sample = r_sample;
    assign o_psum   = r_psum;

endmodule

`default_nettype wire

// ===== design/fir_filter_with_warmup_core.sv =====
// fir_filter_with_warmup_core: top level of the direct-form FIR with warm-up.
// Depends on fwf_pkg, fwf_in_if, fwf_out_if and fwf_tap_cell.
`default_nettype none

// Direct-form FIR filter over TAPS signed Q1.15 samples, built as a row of
// TAPS tap cells. Each cell holds one window sample and one coefficient,
// registers their product, and adds it to the partial sum handed over by its
// older neighbor; the newest sample enters the last cell and the window
// shifts toward cell 0 (the oldest, weighted by coef_0). From acceptance to
// the next acceptance, a filter transaction shifts the window, registers the
// products, lets the partial sum ripple through the row of cells, and then
// waits until the output register is free to load the result there. The
// result is the exact 36-bit Q6.30 sum; for the first TAPS samples after
// reset it is zero (warm-up). A prime transaction loads every cell with its
// value, ends warm-up, gives no result and leaves the block idle. Input ready
// is high while no filter transaction is in flight, also while a finished
// result still waits in the output register. Coefficients are written
// through i_cfg_* with the register index 0..7; indexes at or above TAPS
// have no effect. Write them only while the block is idle.
module fir_filter_with_warmup_core #(
    parameter int TAPS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    fwf_in_if.sink                                    i_in,
    fwf_out_if.source                                 o_res,
    input  wire logic                                 i_cfg_we,
    input  wire logic [fwf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic signed [fwf_pkg::SAMPLE_W-1:0]  i_cfg_data
);

    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int CNT_W  = $clog2(TAPS + 2);
    // Cycles after acceptance until the last partial sum is settled.
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TAPS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);

    fwf_pkg::t_state                      r_state, n_state;
    logic [CNT_W-1:0]                     r_cnt, n_cnt;
    logic [FILL_W-1:0]                    r_fill, n_fill;
    logic                                 r_zero, n_zero;
    logic                                 r_out_valid, n_out_valid;
    logic signed [fwf_pkg::ACC_W-1:0]     r_out_data, n_out_data;

    logic                                 w_accept;
    logic                                 w_do_filter;
    logic                                 w_do_prime;

    logic signed [fwf_pkg::SAMPLE_W-1:0]  w_sample [TAPS];
    logic signed [fwf_pkg::ACC_W-1:0]     w_psum   [TAPS];

    assign i_in.ready  = (r_state == fwf_pkg::ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_do_filter = w_accept && (i_in.kind == fwf_pkg::KIND_FILTER);
    assign w_do_prime  = w_accept && (i_in.kind == fwf_pkg::KIND_PRIME);

    // Row of tap cells: samples move toward cell 0, partial sums toward the
    // last cell.
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        fwf_pkg::t_cell_ctl                  w_ctl;
        logic signed [fwf_pkg::SAMPLE_W-1:0] w_in_sample;
        logic signed [fwf_pkg::ACC_W-1:0]    w_in_psum;

        assign w_ctl.shift   = w_do_filter;
        assign w_ctl.prime   = w_do_prime;
        assign w_ctl.coef_we = i_cfg_we && (i_cfg_idx == fwf_pkg::CFG_IDX_W'(g));

        if (g == TAPS - 1) begin : g_newest
            assign w_in_sample = i_in.sample;
        end else begin : g_inner
            assign w_in_sample = w_sample[g + 1];
        end

        if (g == 0) begin : g_oldest
            assign w_in_psum = '0;
        end else begin : g_chain
            assign w_in_psum = w_psum[g - 1];
        end

        fwf_tap_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (w_in_sample),
            .i_prime_val (i_in.sample),
            .i_coef      (i_cfg_data),
            .i_psum      (w_in_psum),
            .o_sample    (w_sample[g]),
            .o_psum      (w_psum[g])
        );
    end

    // Sequencer: hold BUSY until the sum has rippled through and the
    // output register is free, then load the result.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_data  = r_out_data;

        case (r_state)
            fwf_pkg::ST_IDLE: begin
                if (w_do_prime) begin
                    n_fill = FILL_FULL;
                end else if (w_do_filter) begin
                    // Answer zero while the window is still filling.
                    n_zero  = (r_fill < FILL_FULL);
                    if (r_fill < FILL_FULL) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_cnt   = '0;
                    n_state = fwf_pkg::ST_BUSY;
                end
            end
            fwf_pkg::ST_BUSY: begin
                if (r_cnt != LAST_CNT) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_zero ? '0 : w_psum[TAPS - 1];
                    n_state     = fwf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fwf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_zero      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.filtered = r_out_data;

`ifndef SYNTHESIS
    // A new result appears only at the end of a filter transaction.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == fwf_pkg::ST_BUSY))
        else $error("result appeared without a filter transaction");

    // The fill count never passes the number of taps.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond TAPS");

    // A prime ends warm-up at once and starts no work.
    a_prime_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_prime |=> (r_fill == FILL_FULL) && (r_state == fwf_pkg::ST_IDLE))
        else $error("prime did not mark the window full");

    // Nothing is accepted while a filter transaction is in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwf_pkg::ST_BUSY) |-> !w_accept)
        else $error("transaction accepted while busy");
`endif

endmodule

`default_nettype wire

// ===== bench/fir_filter_with_warmup_core_test.sv =====
// fir_filter_with_warmup_core_test: self-checking bench for the FIR filter with warm-up.
// Predicts each filtered sum from its own window and coefficient copies and checks results.
// Depends on fwf_pkg, fwf_in_if, fwf_out_if and fir_filter_with_warmup_core.
`default_nettype none

module fir_filter_with_warmup_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS             = 8;
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 5;
    // Settle time after the last result, so that the block is surely idle:
    // longer than one whole filter transaction.
    localparam int SETTLE_CYCLES    = 2 * (TAPS + 3);
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 25;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int PRIME_PCT        = 8;
    localparam int TIMEOUT_NS       = 5_000_000;

    typedef logic signed [fwf_pkg::SAMPLE_W-1:0] t_sample;
    typedef logic signed [fwf_pkg::ACC_W-1:0]    t_sum;
    typedef t_sample                             t_coef_set [TAPS];

    typedef enum {
        COEFS_RANDOM,
        COEFS_ALL_MAX,
        COEFS_ALL_MIN,
        COEFS_ALTERNATE,
        COEFS_RAMP,
        COEFS_SMALL
    } t_coef_style;

    localparam t_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    // Warm-up fill: extremes and bit patterns; the last one completes the fill.
    localparam t_sample WARM_UP [TAPS] = '{
        16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
        16'sh0001, 16'sh5555, 16'shaaaa, 16'sh3039
    };

    // Coefficient style per random phase; the extremes are among them.
    localparam t_coef_style PHASE_STYLE [RANDOM_PHASES] = '{
        COEFS_RANDOM, COEFS_ALTERNATE, COEFS_SMALL,
        COEFS_ALL_MIN, COEFS_RANDOM, COEFS_ALL_MAX
    };

    // Shadow of the filter: coefficients, window and fill count, plus the
    // queue of sums still owed by the block.
    class fir_sum_tracker;
        t_sample     coefs [TAPS];
        t_sample     window [TAPS];
        int unsigned filled;
        t_sum        owed_sums [$];
        int unsigned mismatches;

        function new();
            foreach (coefs[i]) begin
                coefs[i]  = '0;
                window[i] = '0;
            end
            filled     = 0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
        endfunction

        function void set_coef(int idx, t_sample value);
            coefs[idx] = value;
        endfunction

        // Append a sum at the tail of the owed queue.
        function void owe_sum(t_sum s);
            owed_sums.insert(owed_sums.size(), s);
        endfunction

        function void note_input(fwf_pkg::t_kind kind, t_sample s);
            logic signed [fwf_pkg::PROD_W-1:0] prod;
            t_sum                              sum;
            int                                i;
            if (kind == fwf_pkg::KIND_PRIME) begin
                foreach (window[j]) window[j] = s;
                filled = TAPS;
            end else if (filled < TAPS) begin
                window[filled] = s;
                filled++;
                owe_sum('0);
            end else begin
                for (i = 0; i < TAPS - 1; i++) window[i] = window[i + 1];
                window[TAPS - 1] = s;
                sum = '0;
                for (i = 0; i < TAPS; i++) begin
                    prod = coefs[i] * window[i];
                    sum  = sum + prod;
                end
                owe_sum(sum);
            end
        endfunction

        function void check_result(t_sum got);
            t_sum want;
            if (owed_sums.size() == 0) begin
                report($sformatf("result %0d with nothing owed", got));
            end else begin
                want = owed_sums[0];
                owed_sums.delete(0);
                if (got !== want) begin
                    report($sformatf("filtered %0d, predicted %0d", got, want));
                end
            end
        endfunction

        function int unsigned outstanding();
            return owed_sums.size();
        endfunction

        function void flag_leftovers();
            foreach (owed_sums[i]) begin
                report($sformatf("sum %0d never arrived", owed_sums[i]));
            end
            owed_sums.delete();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [fwf_pkg::CFG_IDX_W-1:0] cfg_idx;
    t_sample                       cfg_data;

    fwf_in_if  in_ch ();
    fwf_out_if res_ch ();

    fir_sum_tracker sum_book;

    int src_idle_pct;
    int sink_idle_pct;
    int hold_left;
    int long_hold_req;

    fir_filter_with_warmup_core #(
        .TAPS (TAPS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Result receiver: stall at random, or hold ready low for a long stretch
    // when the stimulus asks for one, counting the cycles here.
    always @(posedge i_clk) begin
        if (long_hold_req != 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Observe both channels at each edge. Check the result before noting the
    // input: a result can never belong to the transaction accepted at the
    // same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                sum_book.check_result(res_ch.filtered);
            end
            if (in_ch.valid && in_ch.ready) begin
                sum_book.note_input(fwf_pkg::t_kind'(in_ch.kind), in_ch.sample);
            end
        end
    end

    // Offer one transaction, idling at random first; return at the edge
    // where it is accepted, with valid still high.
    task automatic offer(input fwf_pkg::t_kind kind, input t_sample s);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.kind   <= kind;
        in_ch.sample <= s;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid, wait for every owed sum, then let the block settle so that
    // a trailing prime or filter pass is surely finished.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sum_book.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all coefficient registers back to back; mirror each write at the
    // edge that takes it.
    task automatic load_coefs(input t_coef_set c);
        for (int i = 0; i < TAPS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= fwf_pkg::CFG_IDX_W'(i);
            cfg_data <= c[i];
            @(posedge i_clk);
            sum_book.set_coef(i, c[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic t_coef_set coef_set(t_coef_style style);
        t_coef_set c;
        foreach (c[i]) begin
            case (style)
                COEFS_ALL_MAX:   c[i] = SAMPLE_MAX;
                COEFS_ALL_MIN:   c[i] = SAMPLE_MIN;
                COEFS_ALTERNATE: c[i] = (i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
                // Powers of four: each tap gets its own weight, four to the power of its index.
                COEFS_RAMP:      c[i] = t_sample'(1 << (2 * i));
                COEFS_SMALL:     c[i] = t_sample'(int'($urandom_range(64)) - 32);
                default:         c[i] = t_sample'($urandom);
            endcase
        end
        return c;
    endfunction

    // Lean on the extremes now and then; otherwise take any 16-bit value.
    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            3:       return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        sum_book      = new();
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = fwf_pkg::KIND_FILTER;
        in_ch.sample  = '0;
        res_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        src_idle_pct  = 33;
        sink_idle_pct = 50;
        hold_left     = 0;
        long_hold_req = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Warm-up: every answer is zero, the one that completes the fill too.
        load_coefs(coef_set(COEFS_RAMP));
        foreach (WARM_UP[i]) offer(fwf_pkg::KIND_FILTER, WARM_UP[i]);
        // First full-window sums, then primes, back-to-back primes included.
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MAX);
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MIN);
        offer(fwf_pkg::KIND_PRIME, SAMPLE_MIN);
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MIN);
        offer(fwf_pkg::KIND_PRIME, SAMPLE_MAX);
        offer(fwf_pkg::KIND_PRIME, '0);
        offer(fwf_pkg::KIND_FILTER, 16'sd1);
        offer(fwf_pkg::KIND_FILTER, '0);
        wait_idle();

        // Largest positive and negative sums with extreme coefficients.
        load_coefs(coef_set(COEFS_ALL_MIN));
        offer(fwf_pkg::KIND_PRIME, SAMPLE_MIN);
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MIN);
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MAX);
        wait_idle();
        load_coefs(coef_set(COEFS_ALL_MAX));
        offer(fwf_pkg::KIND_PRIME, SAMPLE_MIN);
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MIN);
        offer(fwf_pkg::KIND_FILTER, SAMPLE_MAX);

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase / 2)
                0: begin
                    src_idle_pct  = 33;
                    sink_idle_pct = 50;
                end
                1: begin
                    src_idle_pct  = 50;
                    sink_idle_pct = 33;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            load_coefs(coef_set(PHASE_STYLE[phase]));
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Back-pressure: starve the receiver while offers keep coming,
                // then pause the sender until everything owed has drained.
                if (phase % 3 == 1 && n == ITEMS_PER_PHASE / 2) begin
                    long_hold_req = LONG_HOLD_CYCLES;
                end
                if (phase % 3 == 1 && n == ITEMS_PER_PHASE / 2 + 40) begin
                    wait_idle();
                end
                offer(($urandom_range(99) < PRIME_PCT) ? fwf_pkg::KIND_PRIME
                                                       : fwf_pkg::KIND_FILTER,
                      pick_sample());
            end
        end

        wait_idle();
        sum_book.flag_leftovers();
        if (sum_book.mismatches == 0) begin
            $display("PASS fir_filter_with_warmup_core");
        end else begin
            $display("FAIL fir_filter_with_warmup_core");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL fir_filter_with_warmup_core");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/fwf_pkg.sv
design/fwf_in_if.sv
design/fwf_out_if.sv
design/fwf_tap_cell.sv
design/fir_filter_with_warmup_core.sv
bench/fir_filter_with_warmup_core_test.sv
